// File: rtl/sbcd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcd_pkg: shared types and constants of the band crack detector
// Register indexes, reset values and the structs passed between modules.
// ---------------------------------------------------------------------------
package sbcd_pkg;

  // Field widths
  localparam int unsigned BinW    = 8;
  localparam int unsigned FreqW   = 13;
  localparam int unsigned MagW    = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned CountW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BAND_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BAND_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAG_THR   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW    = 2'd3;

  // Reset values
  localparam logic [FreqW-1:0]   BandLowRst  = 13'd3500;
  localparam logic [FreqW-1:0]   BandHighRst = 13'd7500;
  localparam logic [MagW-1:0]    MagThrRst   = 32'd35000;
  localparam logic [WindowW-1:0] WindowRst   = 16'd3000;

  // Lowest bin index that can count as a hit (DC and first bin excluded)
  localparam int unsigned MinHitBin = 2;

  // Live configuration
  typedef struct packed {
    logic [FreqW-1:0]   band_low_hz;
    logic [FreqW-1:0]   band_high_hz;
    logic [MagW-1:0]    magnitude_threshold;
    logic [WindowW-1:0] window_ms;
  } sbcd_cfg_t;

  // One result transaction
  typedef struct packed {
    logic              bin_hit;
    logic              frame_done;
    logic              crack_found;
    logic [CountW-1:0] hit_frames;
    logic [TimeW-1:0]  elapsed_ms;
  } sbcd_result_t;

endpackage

// File: rtl/sbcd_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcd_cfg_regs: configuration register file
// Four write-only registers loaded through a plain indexed write port.
// ---------------------------------------------------------------------------
module sbcd_cfg_regs
  import sbcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output sbcd_cfg_t           cfg_o
);

  sbcd_cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BAND_LOW:  cfg_d.band_low_hz         = cfg_data_i[FreqW-1:0];
        CFG_BAND_HIGH: cfg_d.band_high_hz        = cfg_data_i[FreqW-1:0];
        CFG_MAG_THR:   cfg_d.magnitude_threshold = cfg_data_i[MagW-1:0];
        CFG_WINDOW:    cfg_d.window_ms           = cfg_data_i[WindowW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_low_hz         <= BandLowRst;
      cfg_q.band_high_hz        <= BandHighRst;
      cfg_q.magnitude_threshold <= MagThrRst;
      cfg_q.window_ms           <= WindowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/sbcd_hit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcd_hit_test: per-bin band and threshold test
// Checks bin range, centre frequency against the band by cross-multiplying
// with constants (exact, no rounding), and magnitude above threshold.
// ---------------------------------------------------------------------------
module sbcd_hit_test
  import sbcd_pkg::*;
#(
  parameter int unsigned FFT_SIZE       = 256,
  parameter int unsigned SAMPLE_RATE_HZ = 16000
) (
  input  logic [BinW-1:0] bin_index_i,
  input  logic [MagW-1:0] magnitude_i,
  input  sbcd_cfg_t       cfg_i,
  output logic            hit_o
);

  localparam int unsigned HalfFft = FFT_SIZE / 2;
  localparam int unsigned ScaleW  = BinW + $clog2(SAMPLE_RATE_HZ + 1);
  localparam int unsigned BandW   = FreqW + $clog2(FFT_SIZE + 1);
  localparam int unsigned CmpW    = (ScaleW > BandW) ? ScaleW : BandW;

  logic [CmpW-1:0] bin_scaled;
  logic [CmpW-1:0] low_scaled;
  logic [CmpW-1:0] high_scaled;
  logic            in_range;
  logic            in_band;
  logic            above_thr;

  // Constant multiplies: index*FS against band*N
  assign bin_scaled  = CmpW'(bin_index_i) * CmpW'(SAMPLE_RATE_HZ);
  assign low_scaled  = CmpW'(cfg_i.band_low_hz) * CmpW'(FFT_SIZE);
  assign high_scaled = CmpW'(cfg_i.band_high_hz) * CmpW'(FFT_SIZE);

  assign in_range  = (32'(bin_index_i) >= MinHitBin) && (32'(bin_index_i) <= HalfFft);
  assign in_band   = (bin_scaled >= low_scaled) && (bin_scaled <= high_scaled);
  assign above_thr = magnitude_i > cfg_i.magnitude_threshold;

  assign hit_o = in_range && in_band && above_thr;

endmodule

// File: rtl/sbcd_slot_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcd_slot_tracker: three time slots and frame-end evaluation
// Records the first hit of each frame into the next free slot; at a frame end
// with the third slot filled, checks the first-to-third span against the window and clears the slots.
// ---------------------------------------------------------------------------
module sbcd_slot_tracker
  import sbcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               hit_i,
  input  logic [TimeW-1:0]   time_ms_i,
  input  logic               last_bin_i,
  input  logic [WindowW-1:0] window_ms_i,
  output sbcd_result_t       result_o
);

  logic              one_q, one_d;
  logic              two_q, two_d;
  logic              three_q, three_d;
  logic [TimeW-1:0]  first_q, first_d;
  logic [TimeW-1:0]  third_q, third_d;
  logic [CountW-1:0] count_q, count_d;
  logic              rec_q, rec_d;

  logic              fill;
  logic              one_n, two_n, three_n;
  logic [TimeW-1:0]  first_n, third_n;
  logic [CountW-1:0] count_n;
  logic [TimeW-1:0]  elapsed;
  logic              eval_full;

  // Slot fill for this bin
  always_comb begin
    one_n   = one_q;
    two_n   = two_q;
    three_n = three_q;
    first_n = first_q;
    third_n = third_q;
    fill    = 1'b0;
    if (hit_i && !rec_q) begin
      if (!one_q) begin
        one_n   = 1'b1;
        first_n = time_ms_i;
        fill    = 1'b1;
      end else if (!two_q) begin
        two_n   = 1'b1;
        fill    = 1'b1;
      end else if (!three_q) begin
        three_n = 1'b1;
        third_n = time_ms_i;
        fill    = 1'b1;
      end
    end
    count_n = count_q + CountW'(fill);
  end

  assign elapsed   = third_n - first_n;
  assign eval_full = last_bin_i && one_n && three_n;

  // Next state, with frame-end clear
  always_comb begin
    one_d   = one_n;
    two_d   = two_n;
    three_d = three_n;
    first_d = first_n;
    third_d = third_n;
    count_d = count_n;
    rec_d   = last_bin_i ? 1'b0 : (rec_q || fill);
    if (eval_full) begin
      one_d   = 1'b0;
      two_d   = 1'b0;
      three_d = 1'b0;
      first_d = '0;
      third_d = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_q   <= 1'b0;
      two_q   <= 1'b0;
      three_q <= 1'b0;
      first_q <= '0;
      third_q <= '0;
      count_q <= '0;
      rec_q   <= 1'b0;
    end else if (adv_i) begin
      one_q   <= one_d;
      two_q   <= two_d;
      three_q <= three_d;
      first_q <= first_d;
      third_q <= third_d;
      count_q <= count_d;
      rec_q   <= rec_d;
    end
  end

  // Result fields, taken before any clearing
  assign result_o.bin_hit     = hit_i;
  assign result_o.frame_done  = last_bin_i;
  assign result_o.crack_found = eval_full && (elapsed <= TimeW'(window_ms_i));
  assign result_o.hit_frames  = count_n;
  assign result_o.elapsed_ms  = elapsed;

endmodule

// File: rtl/spectral_band_crack_detector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spectral_band_crack_detector: top level
// Input register, hit test and slot tracking, result register.
// ---------------------------------------------------------------------------
// Takes one FFT magnitude bin per clock while the output is not stalled and
// returns one result transaction per bin. The bin is captured in the input
// register, then the band/threshold test and the slot update run
// combinationally and land in the result register. The input register can
// take a bin while a result waits on a stalled output, and the input
// stalls only when both registers are full and the output is stalled. The
// configuration registers may be written only while no bin is in flight.
// ---------------------------------------------------------------------------
module spectral_band_crack_detector
  import sbcd_pkg::*;
#(
  parameter int unsigned FFT_SIZE       = 256,
  parameter int unsigned SAMPLE_RATE_HZ = 16000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // bin input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [BinW-1:0]     bin_index_i,
  input  logic [MagW-1:0]     magnitude_i,
  input  logic [TimeW-1:0]    time_ms_i,
  input  logic                last_bin_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                bin_hit_o,
  output logic                frame_done_o,
  output logic                crack_found_o,
  output logic [CountW-1:0]   hit_frames_o,
  output logic [TimeW-1:0]    elapsed_ms_o
);

  sbcd_cfg_t    cfg;
  sbcd_result_t result;
  sbcd_result_t res_q;

  logic             s1_valid_q;
  logic [BinW-1:0]  s1_bin_q;
  logic [MagW-1:0]  s1_mag_q;
  logic [TimeW-1:0] s1_time_q;
  logic             s1_last_q;
  logic             out_valid_q;

  logic out_free;
  logic adv;
  logic in_take;
  logic hit;

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  sbcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_bin_q  <= bin_index_i;
      s1_mag_q  <= magnitude_i;
      s1_time_q <= time_ms_i;
      s1_last_q <= last_bin_i;
    end
  end

  sbcd_hit_test #(
    .FFT_SIZE       (FFT_SIZE),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_hit (
    .bin_index_i (s1_bin_q),
    .magnitude_i (s1_mag_q),
    .cfg_i       (cfg),
    .hit_o       (hit)
  );

  sbcd_slot_tracker u_slots (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .hit_i       (hit),
    .time_ms_i   (s1_time_q),
    .last_bin_i  (s1_last_q),
    .window_ms_i (cfg.window_ms),
    .result_o    (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_hit_o     = res_q.bin_hit;
  assign frame_done_o  = res_q.frame_done;
  assign crack_found_o = res_q.crack_found;
  assign hit_frames_o  = res_q.hit_frames;
  assign elapsed_ms_o  = res_q.elapsed_ms;

endmodule

// File: rtl/sbcd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcd_checker: port-level checks for the crack detector
// Watches the top-level ports and flags handshake and result slips.
// ---------------------------------------------------------------------------
module sbcd_checker
  import sbcd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                bin_hit_o,
  input logic                frame_done_o,
  input logic                crack_found_o,
  input logic [CountW-1:0]   hit_frames_o,
  input logic [TimeW-1:0]    elapsed_ms_o
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_hit_o) &&
    $stable(frame_done_o) && $stable(crack_found_o) &&
    $stable(hit_frames_o) && $stable(elapsed_ms_o))
    else $error("result changed while stalled");

  // Input backs up only behind a stalled, full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A crack is only reported at a frame end
  a_crack_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crack_found_o |-> frame_done_o)
    else $error("crack reported outside frame end");

  // A crack needs all three slots filled
  a_crack_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crack_found_o |-> hit_frames_o == 2'd3)
    else $error("crack reported with fewer than three slots");

endmodule

bind spectral_band_crack_detector sbcd_checker u_sbcd_checker (.*);
